### src/cvmb_pkg.sv
`default_nettype none

package cvmb_pkg;

    // field widths
    localparam int DIR_W   = 18;
    localparam int POS_W   = 32;
    localparam int ELEM_W  = 32;
    localparam int FRAC_W  = 16;

    // cross product and normalization
    localparam int PROD_W      = 2 * DIR_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int MAG_W       = CROSS_W - 1;
    localparam int LEAD_W      = $clog2(MAG_W);
    localparam int NRM_W       = 31;
    localparam int NRM_TOP     = NRM_W - 1;
    localparam int SQR_W       = 2 * NRM_W;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int Q_W         = FRAC_W + 1;
    localparam int NUM_W       = NRM_W + FRAC_W + 1;

    // dot products
    localparam int DPROD_W = DIR_W + POS_W;
    localparam int DSUM_W  = DPROD_W + 3;
    localparam int DQ_W    = DSUM_W - FRAC_W;

    typedef logic [2:0][DIR_W-1:0]  dvec_t;
    typedef logic [2:0][POS_W-1:0]  pvec_t;
    typedef logic [2:0][ELEM_W-1:0] evec_t;
    typedef logic [2:0][2:0][DIR_W-1:0] dmat_t;

    typedef enum logic [1:0] {
        ROW_RIGHT = 2'd0,
        ROW_UP    = 2'd1,
        ROW_DIR   = 2'd2,
        ROW_TRANS = 2'd3
    } row_t;

    typedef struct packed {
        dvec_t d;
        pvec_t p;
    } side1_t;

    typedef struct packed {
        dvec_t d;
        pvec_t p;
        dvec_t right;
        logic  zero;
    } side2_t;

    typedef struct packed {
        dvec_t right;
        dvec_t v;
        dvec_t d;
        logic  deg;
    } side3_t;

    localparam int SIDE1_W = $bits(side1_t);
    localparam int SIDE2_W = $bits(side2_t);
    localparam int SIDE3_W = $bits(side3_t);

endpackage

`default_nettype wire

### src/cvmb_isqrt.sv
`default_nettype none

// pipelined integer square root, one root bit per stage
module cvmb_isqrt #(
    parameter int SIDE_W = cvmb_pkg::SIDE1_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [cvmb_pkg::SQ_W-1:0]   x,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_vld,
    output logic [cvmb_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]           side_out
);

    localparam int N    = cvmb_pkg::SQRT_STAGES;
    localparam int SQ_W = cvmb_pkg::SQ_W;

    logic [N-1:0]      vld_reg;
    logic [SQ_W-1:0]   x_reg    [N];
    logic [SQ_W-1:0]   res_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    logic [N-1:0]      vld_stg;
    logic [SQ_W-1:0]   x_stg    [N];
    logic [SQ_W-1:0]   res_stg  [N];
    logic [SIDE_W-1:0] side_stg [N];

    assign vld_stg[0]  = in_vld;
    assign x_stg[0]    = x;
    assign res_stg[0]  = '0;
    assign side_stg[0] = side_in;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

            logic [SQ_W-1:0] trial;
            logic            take;

            assign trial = res_stg[k] + BIT;
            assign take  = (x_stg[k] >= trial);

            if (k > 0)
            begin : g_link
                assign vld_stg[k]  = vld_reg[k-1];
                assign x_stg[k]    = x_reg[k-1];
                assign res_stg[k]  = res_reg[k-1];
                assign side_stg[k] = side_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_stg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= take ? (x_stg[k] - trial) : x_stg[k];
                    res_reg[k]  <= take ? ((res_stg[k] >> 1) + BIT) : (res_stg[k] >> 1);
                    side_reg[k] <= side_stg[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[N-1];
    assign root     = res_reg[N-1][cvmb_pkg::ROOT_W-1:0];
    assign side_out = side_reg[N-1];

endmodule

`default_nettype wire

### src/cvmb_div3.sv
`default_nettype none

// three restoring dividers sharing one divisor, one quotient bit per stage
module cvmb_div3 #(
    parameter int SIDE_W = cvmb_pkg::SIDE1_W + 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [2:0][cvmb_pkg::NUM_W-1:0]      num,
    input  logic [cvmb_pkg::ROOT_W-1:0]          den,
    input  logic [SIDE_W-1:0]                    side_in,
    output logic                                 out_vld,
    output logic [2:0][cvmb_pkg::Q_W-1:0]        q,
    output logic [SIDE_W-1:0]                    side_out
);

    localparam int N      = cvmb_pkg::Q_W;
    localparam int NUM_W  = cvmb_pkg::NUM_W;
    localparam int ROOT_W = cvmb_pkg::ROOT_W;

    logic [N-1:0]                  vld_reg;
    logic [2:0][ROOT_W-1:0]        rem_reg  [N];
    logic [2:0][NUM_W-1:0]         num_reg  [N];
    logic [ROOT_W-1:0]             den_reg  [N];
    logic [2:0][N-1:0]             q_reg    [N];
    logic [SIDE_W-1:0]             side_reg [N];

    logic [N-1:0]                  vld_stg;
    logic [2:0][ROOT_W-1:0]        rem_stg  [N];
    logic [2:0][NUM_W-1:0]         num_stg  [N];
    logic [ROOT_W-1:0]             den_stg  [N];
    logic [2:0][N-1:0]             q_stg    [N];
    logic [SIDE_W-1:0]             side_stg [N];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_stg[0][i] = ROOT_W'(num[i][NUM_W-1:N]);
        end
    end

    assign vld_stg[0]  = in_vld;
    assign num_stg[0]  = num;
    assign den_stg[0]  = den;
    assign q_stg[0]    = '0;
    assign side_stg[0] = side_in;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            localparam int BI = N - 1 - k;

            logic [2:0][ROOT_W:0]   rs;
            logic [2:0][ROOT_W:0]   diff;
            logic [2:0]             take;
            logic [2:0][ROOT_W-1:0] rem_n;
            logic [2:0][N-1:0]      q_n;

            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rs[i]    = {rem_stg[k][i], num_stg[k][i][BI]};
                    diff[i]  = rs[i] - {1'b0, den_stg[k]};
                    take[i]  = (rs[i] >= {1'b0, den_stg[k]});
                    rem_n[i] = take[i] ? diff[i][ROOT_W-1:0] : rs[i][ROOT_W-1:0];
                    q_n[i]   = {q_stg[k][i][N-2:0], take[i]};
                end
            end

            if (k > 0)
            begin : g_link
                assign vld_stg[k]  = vld_reg[k-1];
                assign rem_stg[k]  = rem_reg[k-1];
                assign num_stg[k]  = num_reg[k-1];
                assign den_stg[k]  = den_reg[k-1];
                assign q_stg[k]    = q_reg[k-1];
                assign side_stg[k] = side_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_stg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_n;
                    num_reg[k]  <= num_stg[k];
                    den_reg[k]  <= den_stg[k];
                    q_reg[k]    <= q_n;
                    side_reg[k] <= side_stg[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[N-1];
    assign q        = q_reg[N-1];
    assign side_out = side_reg[N-1];

endmodule

`default_nettype wire

### src/cvmb_norm.sv
`default_nettype none

// normalize(cross(a, b)) to Q2.16 unit components
module cvmb_norm #(
    parameter int SIDE_W = cvmb_pkg::SIDE1_W
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  cvmb_pkg::dvec_t a,
    input  cvmb_pkg::dvec_t b,
    input  logic [SIDE_W-1:0] side_in,
    output logic            out_vld,
    output cvmb_pkg::dvec_t r,
    output logic            zero,
    output logic [SIDE_W-1:0] side_out
);

    localparam int PROD_W  = cvmb_pkg::PROD_W;
    localparam int CROSS_W = cvmb_pkg::CROSS_W;
    localparam int MAG_W   = cvmb_pkg::MAG_W;
    localparam int LEAD_W  = cvmb_pkg::LEAD_W;
    localparam int NRM_W   = cvmb_pkg::NRM_W;
    localparam int NRM_TOP = cvmb_pkg::NRM_TOP;
    localparam int SQR_W   = cvmb_pkg::SQR_W;
    localparam int SQ_W    = cvmb_pkg::SQ_W;
    localparam int ROOT_W  = cvmb_pkg::ROOT_W;
    localparam int NUM_W   = cvmb_pkg::NUM_W;
    localparam int Q_W     = cvmb_pkg::Q_W;
    localparam int FRAC_W  = cvmb_pkg::FRAC_W;
    localparam int UNIT_W  = cvmb_pkg::DIR_W;
    localparam int SQS_W   = SIDE_W + 4 + 3 * NRM_W;
    localparam int DVS_W   = SIDE_W + 4;

    // front stages before the root
    logic [5:0]                 pre_vld_reg;
    logic [SIDE_W-1:0]          side_pre_reg [6];

    logic signed [PROD_W-1:0]   prod_reg [6];
    logic signed [CROSS_W-1:0]  c_reg    [3];
    logic [2:0][MAG_W-1:0]      mag_reg;
    logic [LEAD_W-1:0]          lead_reg;
    logic [2:0]                 sign3_reg, sign4_reg, sign5_reg, sign6_reg;
    logic                       zero3_reg, zero4_reg, zero5_reg, zero6_reg;
    logic [2:0][NRM_W-1:0]      a4_reg, a5_reg, a6_reg;
    logic [2:0][SQR_W-1:0]      sq_reg;
    logic [SQ_W-1:0]            sum_reg;

    logic [2:0][MAG_W-1:0]      mag_c;
    logic [2:0]                 sign_c;
    logic [MAG_W-1:0]           or_c;
    logic [LEAD_W-1:0]          lead_c;
    logic [2:0][NRM_W-1:0]      a_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sign_c[i] = c_reg[i][CROSS_W-1];
            mag_c[i]  = sign_c[i] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
        end
        or_c   = mag_c[0] | mag_c[1] | mag_c[2];
        lead_c = '0;
        for (int j = 0; j < MAG_W; j++)
        begin
            if (or_c[j])
            begin
                lead_c = LEAD_W'(j);
            end
        end
    end

    // bring the largest magnitude to bit NRM_TOP
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (lead_reg > LEAD_W'(NRM_TOP))
            begin
                a_c[i] = NRM_W'(mag_reg[i] >> (lead_reg - LEAD_W'(NRM_TOP)));
            end
            else
            begin
                a_c[i] = NRM_W'(mag_reg[i] << (LEAD_W'(NRM_TOP) - lead_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
        end
        else if (en)
        begin
            pre_vld_reg <= {pre_vld_reg[4:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pre_reg[0] <= side_in;
            for (int s = 1; s < 6; s++)
            begin
                side_pre_reg[s] <= side_pre_reg[s-1];
            end

            prod_reg[0] <= $signed(a[1]) * $signed(b[2]);
            prod_reg[1] <= $signed(a[2]) * $signed(b[1]);
            prod_reg[2] <= $signed(a[2]) * $signed(b[0]);
            prod_reg[3] <= $signed(a[0]) * $signed(b[2]);
            prod_reg[4] <= $signed(a[0]) * $signed(b[1]);
            prod_reg[5] <= $signed(a[1]) * $signed(b[0]);

            c_reg[0] <= CROSS_W'(prod_reg[0]) - CROSS_W'(prod_reg[1]);
            c_reg[1] <= CROSS_W'(prod_reg[2]) - CROSS_W'(prod_reg[3]);
            c_reg[2] <= CROSS_W'(prod_reg[4]) - CROSS_W'(prod_reg[5]);

            mag_reg   <= mag_c;
            sign3_reg <= sign_c;
            lead_reg  <= lead_c;
            zero3_reg <= (or_c == '0);

            a4_reg    <= a_c;
            sign4_reg <= sign3_reg;
            zero4_reg <= zero3_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= a4_reg[i] * a4_reg[i];
            end
            a5_reg    <= a4_reg;
            sign5_reg <= sign4_reg;
            zero5_reg <= zero4_reg;

            sum_reg   <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            a6_reg    <= a5_reg;
            sign6_reg <= sign5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // root of the sum of squares
    logic                   sq_vld;
    logic [ROOT_W-1:0]      root;
    logic [SQS_W-1:0]       sq_side;
    logic [SIDE_W-1:0]      side_s;
    logic                   zero_s;
    logic [2:0]             sign_s;
    logic [2:0][NRM_W-1:0]  a_s;

    cvmb_isqrt #(
        .SIDE_W (SQS_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (pre_vld_reg[5]),
        .x        (sum_reg),
        .side_in  ({side_pre_reg[5], zero6_reg, sign6_reg, a6_reg}),
        .out_vld  (sq_vld),
        .root     (root),
        .side_out (sq_side)
    );

    assign {side_s, zero_s, sign_s, a_s} = sq_side;

    // numerators with half the divisor added for rounding
    logic                   vld7_reg;
    logic [2:0][NUM_W-1:0]  num_reg;
    logic [ROOT_W-1:0]      den_reg;
    logic [DVS_W-1:0]       dside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld7_reg <= 1'b0;
        end
        else if (en)
        begin
            vld7_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= NUM_W'({a_s[i], {FRAC_W{1'b0}}}) + NUM_W'(root >> 1);
            end
            den_reg   <= root;
            dside_reg <= {side_s, zero_s, sign_s};
        end
    end

    logic                   dv_vld;
    logic [2:0][Q_W-1:0]    quo;
    logic [DVS_W-1:0]       dv_side;
    logic [SIDE_W-1:0]      side_d;
    logic                   zero_d;
    logic [2:0]             sign_d;

    cvmb_div3 #(
        .SIDE_W (DVS_W)
    ) u_div3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld7_reg),
        .num      (num_reg),
        .den      (den_reg),
        .side_in  (dside_reg),
        .out_vld  (dv_vld),
        .q        (quo),
        .side_out (dv_side)
    );

    assign {side_d, zero_d, sign_d} = dv_side;

    // sign and zero flag applied
    logic                   vld8_reg;
    cvmb_pkg::dvec_t        r_reg;
    logic                   zero8_reg;
    logic [SIDE_W-1:0]      side8_reg;
    logic [2:0][UNIT_W-1:0] qe;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qe[i] = UNIT_W'(quo[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld8_reg <= 1'b0;
        end
        else if (en)
        begin
            vld8_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (zero_d)
                begin
                    r_reg[i] <= '0;
                end
                else
                begin
                    r_reg[i] <= sign_d[i] ? (-qe[i]) : qe[i];
                end
            end
            zero8_reg <= zero_d;
            side8_reg <= side_d;
        end
    end

    assign out_vld  = vld8_reg;
    assign r        = r_reg;
    assign zero     = zero8_reg;
    assign side_out = side8_reg;

endmodule

`default_nettype wire

### src/cvmb_dot.sv
`default_nettype none

// three dot products against the position, rounded and saturated to Q16.16
module cvmb_dot #(
    parameter int SIDE_W = cvmb_pkg::SIDE3_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  cvmb_pkg::dmat_t   vec,
    input  cvmb_pkg::pvec_t   p,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output cvmb_pkg::evec_t   t,
    output logic [SIDE_W-1:0] side_out
);

    localparam int DPROD_W = cvmb_pkg::DPROD_W;
    localparam int DSUM_W  = cvmb_pkg::DSUM_W;
    localparam int DQ_W    = cvmb_pkg::DQ_W;
    localparam int ELEM_W  = cvmb_pkg::ELEM_W;
    localparam int FRAC_W  = cvmb_pkg::FRAC_W;

    logic [1:0]                 vld_reg;
    logic signed [DPROD_W-1:0]  prod_reg [3][3];
    logic [SIDE_W-1:0]          side1_reg, side2_reg;
    cvmb_pkg::evec_t            t_reg;

    logic signed [DSUM_W-1:0]   sum_c [3];
    logic [DQ_W-1:0]            q_c   [3];
    cvmb_pkg::evec_t            t_c;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum_c[j] = DSUM_W'(prod_reg[j][0]) + DSUM_W'(prod_reg[j][1])
                     + DSUM_W'(prod_reg[j][2]) + DSUM_W'(1 << (FRAC_W - 1));
            q_c[j]   = sum_c[j][DSUM_W-1:FRAC_W];
            // saturate when the bits above the result are not a pure sign
            if (q_c[j][DQ_W-1:ELEM_W-1] == '0 || q_c[j][DQ_W-1:ELEM_W-1] == '1)
            begin
                t_c[j] = q_c[j][ELEM_W-1:0];
            end
            else if (q_c[j][DQ_W-1])
            begin
                t_c[j] = {1'b1, {(ELEM_W-1){1'b0}}};
            end
            else
            begin
                t_c[j] = {1'b0, {(ELEM_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[j][i] <= $signed(vec[j][i]) * $signed(p[i]);
                end
            end
            side1_reg <= side_in;
            t_reg     <= t_c;
            side2_reg <= side1_reg;
        end
    end

    assign out_vld  = vld_reg[1];
    assign t        = t_reg;
    assign side_out = side2_reg;

endmodule

`default_nettype wire

### src/camera_view_matrix_builder.sv
`default_nettype none

// channel   direction  handshake            payload
// in        sink       in_valid/in_ready    dir_*, up_*, pos_*
// out       source     out_valid/out_ready  row_index, elem_*, degenerate, last_row
//
// one camera item in gives four rows out, right, recomputed up, direction, translations
// the pipeline takes an item every cycle unless a stalled output holds it (in_ready low)
// four rows per item leave through the output row register, so the sustained rate
//   is set by that single output port
// rst_n clears every valid bit and the row counter; data registers are not reset
// a stalled output freezes the whole pipeline once an item waits at its end; nothing is dropped or repeated
module camera_view_matrix_builder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [17:0] dir_x,
    input  logic [17:0] dir_y,
    input  logic [17:0] dir_z,
    input  logic [17:0] up_x,
    input  logic [17:0] up_y,
    input  logic [17:0] up_z,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  row_index,
    output logic [31:0] elem_x,
    output logic [31:0] elem_y,
    output logic [31:0] elem_z,
    output logic        degenerate,
    output logic        last_row
);

    localparam int ELEM_W = cvmb_pkg::ELEM_W;

    // global advance: the pipeline moves unless its last item cannot be handed over
    logic en;
    logic ser_take;
    logic dot_vld;

    assign en       = !dot_vld || ser_take;
    assign in_ready = en;

    // first normalization: right = normalize(cross(d, u))
    cvmb_pkg::side1_t s1_in, s1_out;
    cvmb_pkg::dvec_t  d_in, u_in, right1;
    logic             n1_vld, zero1;

    assign d_in     = {dir_z, dir_y, dir_x};
    assign u_in     = {up_z, up_y, up_x};
    assign s1_in.d  = d_in;
    assign s1_in.p  = {pos_z, pos_y, pos_x};

    cvmb_norm #(
        .SIDE_W (cvmb_pkg::SIDE1_W)
    ) u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid && in_ready),
        .a        (d_in),
        .b        (u_in),
        .side_in  (s1_in),
        .out_vld  (n1_vld),
        .r        (right1),
        .zero     (zero1),
        .side_out (s1_out)
    );

    // second normalization: v = normalize(cross(d, right))
    cvmb_pkg::side2_t s2_in, s2_out;
    cvmb_pkg::dvec_t  v2;
    logic             n2_vld, zero2;

    assign s2_in.d     = s1_out.d;
    assign s2_in.p     = s1_out.p;
    assign s2_in.right = right1;
    assign s2_in.zero  = zero1;

    cvmb_norm #(
        .SIDE_W (cvmb_pkg::SIDE2_W)
    ) u_norm_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (n1_vld),
        .a        (s1_out.d),
        .b        (right1),
        .side_in  (s2_in),
        .out_vld  (n2_vld),
        .r        (v2),
        .zero     (zero2),
        .side_out (s2_out)
    );

    // either cross product zero clears both basis rows
    logic             deg;
    cvmb_pkg::side3_t s3_in, s3_out;
    cvmb_pkg::dmat_t  dot_vec;
    cvmb_pkg::evec_t  trans;

    assign deg          = s2_out.zero || zero2;
    assign s3_in.right  = deg ? '0 : s2_out.right;
    assign s3_in.v      = deg ? '0 : v2;
    assign s3_in.d      = s2_out.d;
    assign s3_in.deg    = deg;
    assign dot_vec      = {s3_in.d, s3_in.v, s3_in.right};

    cvmb_dot #(
        .SIDE_W (cvmb_pkg::SIDE3_W)
    ) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (n2_vld),
        .vec      (dot_vec),
        .p        (s2_out.p),
        .side_in  (s3_in),
        .out_vld  (dot_vld),
        .t        (trans),
        .side_out (s3_out)
    );

    // output row register: holds one finished matrix, sends it a row at a time
    logic             ser_vld_reg, ser_vld_next;
    cvmb_pkg::row_t   row_reg, row_next;
    cvmb_pkg::side3_t mat_reg;
    cvmb_pkg::evec_t  trans_reg;
    logic             out_fire;

    assign out_fire = ser_vld_reg && out_ready;
    assign ser_take = !ser_vld_reg || (out_ready && row_reg == cvmb_pkg::ROW_TRANS);

    always_comb
    begin
        ser_vld_next = ser_vld_reg;
        row_next     = row_reg;
        if (out_fire)
        begin
            case (row_reg)
                cvmb_pkg::ROW_RIGHT: row_next = cvmb_pkg::ROW_UP;
                cvmb_pkg::ROW_UP:    row_next = cvmb_pkg::ROW_DIR;
                cvmb_pkg::ROW_DIR:   row_next = cvmb_pkg::ROW_TRANS;
                cvmb_pkg::ROW_TRANS:
                begin
                    row_next     = cvmb_pkg::ROW_RIGHT;
                    ser_vld_next = 1'b0;
                end
                default:             row_next = cvmb_pkg::ROW_RIGHT;
            endcase
        end
        if (dot_vld && ser_take)
        begin
            ser_vld_next = 1'b1;
            row_next     = cvmb_pkg::ROW_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            row_reg     <= cvmb_pkg::ROW_RIGHT;
        end
        else
        begin
            ser_vld_reg <= ser_vld_next;
            row_reg     <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dot_vld && ser_take)
        begin
            mat_reg   <= s3_out;
            trans_reg <= trans;
        end
    end

    // row select, direction and basis rows sign-extended from Q2.16
    always_comb
    begin
        case (row_reg)
            cvmb_pkg::ROW_RIGHT:
            begin
                elem_x = ELEM_W'($signed(mat_reg.right[0]));
                elem_y = ELEM_W'($signed(mat_reg.right[1]));
                elem_z = ELEM_W'($signed(mat_reg.right[2]));
            end
            cvmb_pkg::ROW_UP:
            begin
                elem_x = ELEM_W'($signed(mat_reg.v[0]));
                elem_y = ELEM_W'($signed(mat_reg.v[1]));
                elem_z = ELEM_W'($signed(mat_reg.v[2]));
            end
            cvmb_pkg::ROW_DIR:
            begin
                elem_x = ELEM_W'($signed(mat_reg.d[0]));
                elem_y = ELEM_W'($signed(mat_reg.d[1]));
                elem_z = ELEM_W'($signed(mat_reg.d[2]));
            end
            default:
            begin
                elem_x = trans_reg[0];
                elem_y = trans_reg[1];
                elem_z = trans_reg[2];
            end
        endcase
    end

    assign out_valid  = ser_vld_reg;
    assign row_index  = row_reg;
    assign degenerate = mat_reg.deg;
    assign last_row   = (row_reg == cvmb_pkg::ROW_TRANS);

    // rows of one matrix go out in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_row
        |=> out_valid && (row_index == $past(row_index) + 2'd1))
    else $error("row sequence broken");

    // degenerate item carries zero basis rows
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate
        && (row_index == cvmb_pkg::ROW_RIGHT || row_index == cvmb_pkg::ROW_UP)
        |-> elem_x == '0 && elem_y == '0 && elem_z == '0)
    else $error("degenerate basis row not zero");

    // unit basis components stay within one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate
        && (row_index == cvmb_pkg::ROW_RIGHT || row_index == cvmb_pkg::ROW_UP)
        |-> $signed(elem_x) <= 65536 && $signed(elem_x) >= -65536
         && $signed(elem_y) <= 65536 && $signed(elem_y) >= -65536
         && $signed(elem_z) <= 65536 && $signed(elem_z) >= -65536)
    else $error("basis component out of range");

endmodule

`default_nettype wire
